// ===== design/hmcb_pkg.sv =====
// Package for the chained-bucket hash map: sizes, opcodes and shared types.
// No dependencies.
package hmcb_pkg;
    localparam int BUCKETS = 1024;
    localparam int WAYS    = 4;
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int KEY_W   = 31;
    localparam int VAL_W   = 31;
    localparam int ROW_W   = WAYS * (KEY_W + VAL_W);
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [BKT_W-1:0] bkt;
    } t_req;

    // Bucket index: key modulo BUCKETS. Power-of-two sizes reduce to a mask;
    // other sizes take one reciprocal multiply plus a small correction.
    function automatic logic [BKT_W-1:0] f_bucket(input logic [KEY_W-1:0] key);
        logic [63:0] q;
        logic [63:0] r;
        if ((BUCKETS & (BUCKETS - 1)) == 0) begin
            f_bucket = key[BKT_W-1:0];
        end else begin
            q = ({33'd0, key} * (64'(2) ** 31 / 64'(BUCKETS))) >> 31;
            r = {33'd0, key} - q * 64'(BUCKETS);
            if (r >= 64'(BUCKETS)) begin
                r = r - 64'(BUCKETS);
            end
            if (r >= 64'(BUCKETS)) begin
                r = r - 64'(BUCKETS);
            end
            f_bucket = r[BKT_W-1:0];
        end
    endfunction
endpackage

// ===== design/hmcb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hmcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/hmcb_front.sv =====
// Front end: accepts requests, computes the bucket, holds a two-entry queue.
// Depends on hmcb_pkg.
module hmcb_front import hmcb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [1:0]       i_opcode,
    input  logic [KEY_W-1:0] i_lookup_key,
    input  logic [VAL_W-1:0] i_store_value,
    output logic             o_req_valid,
    output t_req             o_req,
    input  logic             i_req_take
);
    t_req       r_q [2];
    logic       r_wp, r_rp, n_wp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_in, w_out;

    assign o_full      = (r_cnt == 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign w_in        = i_push && !o_full;
    assign w_out       = i_req_take && o_req_valid;

    always_comb begin
        n_wp  = w_in  ? ~r_wp : r_wp;
        n_rp  = w_out ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_in} - {1'b0, w_out};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_in) begin
            r_q[r_wp] <= '{op: i_opcode, key: i_lookup_key, val: i_store_value,
                           bkt: f_bucket(i_lookup_key)};
        end
    end
endmodule

// ===== design/hmcb_back.sv =====
// Back end: reads a bucket row, matches ways, writes back, queues the result.
// Depends on hmcb_pkg and hmcb_ram.
module hmcb_back import hmcb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  t_req               i_req,
    output logic               o_req_take,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [31:0] o_read_value,
    output logic               o_hit,
    output logic               o_bucket_full
);
    localparam logic [0:0] ST_READ = 1'b0;
    localparam logic [0:0] ST_EXEC = 1'b1;

    logic [0:0]       r_state, n_state;
    t_req             r_cur;
    // Clearing pass over the valid RAM after reset.
    logic             r_clr_busy;
    logic [BKT_W-1:0] r_clr;
    logic [WAYS-1:0]  w_vrow;
    logic             w_vwe;
    logic [BKT_W-1:0] w_vwaddr;
    logic [WAYS-1:0]  w_vwdata;
    logic [ROW_W-1:0] w_rrow, w_wrow;
    logic             w_we, w_res;
    logic [WAY_W-1:0] w_mway, w_fway;
    logic             w_match, w_free;
    logic [31:0]      w_rd;
    logic             w_hit, w_bf;
    logic [WAYS-1:0]  w_nvrow;
    // Result holding register (one deep).
    logic             r_rv;
    logic [31:0]      r_rd;
    logic             r_hit, r_bf;

    hmcb_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_row (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_cur.bkt), .i_wdata(w_wrow),
        .i_raddr(i_req.bkt), .o_rdata(w_rrow)
    );

    hmcb_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_valid (
        .i_clk(i_clk), .i_we(w_vwe), .i_waddr(w_vwaddr), .i_wdata(w_vwdata),
        .i_raddr(i_req.bkt), .o_rdata(w_vrow)
    );

    assign w_vwe      = r_clr_busy || w_res;
    assign w_vwaddr   = r_clr_busy ? r_clr : r_cur.bkt;
    assign w_vwdata   = r_clr_busy ? '0 : w_nvrow;
    // A result popped in this cycle frees the holding register in time for
    // the request taken now, which finishes in the next cycle.
    assign o_req_take = (r_state == ST_READ) && !r_clr_busy && i_req_valid
                        && (!r_rv || i_pop);

    always_comb begin
        w_res   = (r_state == ST_EXEC);
        w_match = 1'b0;
        w_free  = 1'b0;
        w_mway  = '0;
        w_fway  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_vrow[w] && w_rrow[w*(KEY_W+VAL_W)+VAL_W +: KEY_W] == r_cur.key) begin
                w_match = 1'b1;
                w_mway  = WAY_W'(w);
            end
            if (!w_vrow[w]) begin
                w_free = 1'b1;
                w_fway = WAY_W'(w);
            end
        end
        w_wrow  = w_rrow;
        w_nvrow = w_vrow;
        w_we    = 1'b0;
        w_rd    = 32'hFFFF_FFFF;
        w_hit   = (r_cur.op != OP_UNUSED) && w_match;
        w_bf    = 1'b0;
        case (r_cur.op)
            OP_PUT: begin
                if (w_match) begin
                    w_wrow[w_mway*(KEY_W+VAL_W) +: VAL_W] = r_cur.val;
                    w_we = w_res;
                end else if (w_free) begin
                    w_wrow[w_fway*(KEY_W+VAL_W) +: KEY_W+VAL_W] = {r_cur.key, r_cur.val};
                    w_nvrow[w_fway] = 1'b1;
                    w_we = w_res;
                end else begin
                    w_bf = 1'b1;
                end
            end
            OP_GET: begin
                if (w_match) begin
                    w_rd = {1'b0, w_rrow[w_mway*(KEY_W+VAL_W) +: VAL_W]};
                end
            end
            OP_REMOVE: begin
                if (w_match) begin
                    w_nvrow[w_mway] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        n_state = o_req_take ? ST_EXEC : ST_READ;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_READ;
            r_rv       <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr      <= '0;
        end else begin
            r_state <= n_state;
            if (r_clr_busy) begin
                r_clr <= r_clr + BKT_W'(1);
                if (r_clr == BKT_W'(BUCKETS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_res) begin
                r_rv <= 1'b1;
            end else if (i_pop) begin
                r_rv <= 1'b0;
            end
        end
        if (o_req_take) begin
            r_cur <= i_req;
        end
        if (w_res) begin
            r_rd  <= w_rd;
            r_hit <= w_hit;
            r_bf  <= w_bf;
        end
    end

    assign o_empty       = !r_rv;
    assign o_read_value  = r_rd;
    assign o_hit         = r_hit;
    assign o_bucket_full = r_bf;
endmodule

// ===== design/hash_map_chained_buckets_unit.sv =====
// Top level of the chained-bucket hash map.
// Depends on hmcb_pkg, hmcb_front and hmcb_back.
//
// A key-to-value map with WAYS slots per bucket; the bucket is the key modulo
// BUCKETS. Each request is put, get, remove or the unused opcode and yields
// exactly one result. Requests enter a two-entry queue in the front end, so
// pushes continue while the back end works. The back end serves a request in
// a read state, which reads the bucket row and its valid bits from RAM, and
// an execute state, which matches, updates and writes them back; it takes no
// new request in the execute state, so a request is finished before the next
// one starts. Slot valid bits live in a RAM that is cleared by a pass over
// all BUCKETS rows (1024) after reset; during that pass requests are queued
// (up to two) but none is served.
// A finished result waits in a register until popped; while it waits the back
// end holds the next request.
module hash_map_chained_buckets_unit import hmcb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_opcode,
    input  logic [KEY_W-1:0]   i_lookup_key,
    input  logic [VAL_W-1:0]   i_store_value,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_read_value,
    output logic               o_hit,
    output logic               o_bucket_full
);
    logic w_req_valid, w_req_take;
    t_req w_req;

    hmcb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_opcode(i_opcode), .i_lookup_key(i_lookup_key),
        .i_store_value(i_store_value), .o_req_valid(w_req_valid),
        .o_req(w_req), .i_req_take(w_req_take)
    );

    hmcb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(w_req_valid),
        .i_req(w_req), .o_req_take(w_req_take), .o_empty(empty), .i_pop(pop),
        .o_read_value(o_read_value), .o_hit(o_hit), .o_bucket_full(o_bucket_full)
    );
endmodule

// ===== sim/hash_map_chained_buckets_unit_tb.sv =====
// Self-checking testbench for the chained-bucket hash map unit.
// Depends on hmcb_pkg and hash_map_chained_buckets_unit; predicts each result from
// a behavioral copy of the bucket slots and checks every popped result in order.
module hash_map_chained_buckets_unit_tb;
    import hmcb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = BUCKETS * WAYS;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] rd;
        logic               hit;
        logic               full;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic [1:0]         i_opcode = '0;
    logic [KEY_W-1:0]   i_lookup_key = '0;
    logic [VAL_W-1:0]   i_store_value = '0;
    logic               pop = 1'b0;
    logic               full;
    logic               empty;
    logic signed [31:0] o_read_value;
    logic               o_hit;
    logic               o_bucket_full;

    hash_map_chained_buckets_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_opcode      (i_opcode),
        .i_lookup_key  (i_lookup_key),
        .i_store_value (i_store_value),
        .empty         (empty),
        .pop           (pop),
        .o_read_value  (o_read_value),
        .o_hit         (o_hit),
        .o_bucket_full (o_bucket_full)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the map contents.
    bit             map_valid [SLOTS];
    bit [KEY_W-1:0] map_key   [SLOTS];
    bit [VAL_W-1:0] map_val   [SLOTS];

    t_result pending_results[$];
    int      error_count = 0;
    int      idle_cycles = 0;
    bit      hold_pop = 1'b0;

    // Computes the result of one request and applies its effect to the shadow map.
    function automatic t_result map_apply(logic [1:0] op, logic [KEY_W-1:0] key,
                                          logic [VAL_W-1:0] val);
        t_result res;
        int      base;
        int      match;
        int      free_way;
        base     = int'(key % BUCKETS) * WAYS;
        match    = -1;
        free_way = -1;
        res.rd   = -32'sd1;
        res.hit  = 1'b0;
        res.full = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (map_valid[base + w]) begin
                if (match < 0 && map_key[base + w] == key) match = w;
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        if (op == OP_PUT || op == OP_GET || op == OP_REMOVE) res.hit = (match >= 0);
        case (op)
            OP_PUT: begin
                if (match >= 0) begin
                    map_val[base + match] = val;
                end else if (free_way >= 0) begin
                    map_valid[base + free_way] = 1'b1;
                    map_key[base + free_way]   = key;
                    map_val[base + free_way]   = val;
                end else begin
                    res.full = 1'b1;
                end
            end
            OP_GET: begin
                if (match >= 0) res.rd = {1'b0, map_val[base + match]};
            end
            OP_REMOVE: begin
                if (match >= 0) map_valid[base + match] = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offers one request after a random gap and waits until it is accepted.
    // Push stays high when the next request follows with no gap.
    task automatic send_request(logic [1:0] op, logic [KEY_W-1:0] key,
                                logic [VAL_W-1:0] val);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_opcode      <= op;
        i_lookup_key  <= key;
        i_store_value <= val;
        do @(posedge i_clk); while (full);
        pending_results.push_back(map_apply(op, key, val));
    endtask

    // A key that lands in a chosen bucket, with random upper bits.
    function automatic logic [KEY_W-1:0] key_in_bucket(int bkt);
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom);
        return KEY_W'(k - (k % BUCKETS) + KEY_W'(bkt));
    endfunction

    // Field extremes, every opcode and all listed special cases.
    task automatic test_directed();
        send_request(OP_GET, '0, '0);
        send_request(OP_REMOVE, '0, '0);
        send_request(OP_PUT, '0, '0);
        send_request(OP_GET, '0, '1);
        send_request(OP_PUT, '0, '1);
        send_request(OP_GET, '0, '0);
        send_request(OP_PUT, '1, '1);
        send_request(OP_GET, '1, '0);
        send_request(OP_UNUSED, '1, '1);
        send_request(OP_UNUSED, '0, '0);
        // Fill one bucket, then overflow it.
        for (int i = 0; i < WAYS + 1; i++)
            send_request(OP_PUT, KEY_W'(5 + i * BUCKETS), VAL_W'(i));
        send_request(OP_REMOVE, KEY_W'(5 + BUCKETS), '0);
        send_request(OP_GET, KEY_W'(5 + BUCKETS), '0);
        send_request(OP_PUT, KEY_W'(5 + WAYS * BUCKETS), '1);
        send_request(OP_GET, KEY_W'(5 + WAYS * BUCKETS), '0);
        send_request(OP_REMOVE, '1, '0);
        send_request(OP_GET, '1, '0);
    endtask

    // Random traffic confined to a few buckets so that keys collide, buckets fill
    // and removes find their targets; full-width keys are mixed in as noise.
    task automatic test_random(int count);
        logic [KEY_W-1:0] used_keys[$];
        logic [KEY_W-1:0] key;
        logic [1:0]       op;
        int               sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 10 || used_keys.size() == 0) begin
                key = KEY_W'($urandom);
            end else if (sel < 50) begin
                key = key_in_bucket($urandom_range(0, 7));
                used_keys.push_back(key);
            end else begin
                key = used_keys[$urandom_range(0, used_keys.size() - 1)];
            end
            if (used_keys.size() > 64) void'(used_keys.pop_front());
            sel = $urandom_range(0, 99);
            op  = (sel < 40) ? OP_PUT : (sel < 70) ? OP_GET :
                  (sel < 97) ? OP_REMOVE : OP_UNUSED;
            send_request(op, key, VAL_W'($urandom));
        end
    endtask

    // The receiver stops popping for a long stretch while requests keep coming,
    // so the internal queue fills and full must throttle the sender.
    task automatic test_backpressure();
        hold_pop = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_pop = 1'b0;
            end
            test_random(30);
        join
    endtask

    // Result side: random pop stalls, and an in-order compare of each result.
    initial begin : result_checker
        t_result want;
        int      stall;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (stall > 0 || hold_pop) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
                while (hold_pop) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request pending: rd %0d hit %0b full %0b",
                         $time, o_read_value, o_hit, o_bucket_full);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_value !== want.rd) begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, want.rd, o_read_value);
                    error_count++;
                end
                if (o_hit !== want.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, o_hit);
                    error_count++;
                end
                if (o_bucket_full !== want.full) begin
                    $display("%0t: bucket_full expected %0b actual %0b",
                             $time, want.full, o_bucket_full);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither a request nor a result is handed over.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(900);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
